// ===== rtl/wst_pkg.sv =====
package wst_pkg;

    localparam int NUM_SETS    = 8;
    localparam int IDS_PER_SET = 9;
    localparam int COORD_WIDTH = 32;

    localparam int CMD_W   = 3;
    localparam int SETNUM_W = 4;
    localparam int ID_W    = 4;
    localparam int POS_W   = 32;

    localparam int SET_IDX_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int SLOT_IDX_W = (IDS_PER_SET > 1) ? $clog2(IDS_PER_SET) : 1;
    localparam int SLOT_DEPTH = NUM_SETS * IDS_PER_SET;
    localparam int SLOT_ADDR_W = (SLOT_DEPTH > 1) ? $clog2(SLOT_DEPTH) : 1;
    localparam int SLOT_DATA_W = 2 * COORD_WIDTH;

    typedef enum logic [CMD_W-1:0] {
        CMD_ADD    = 3'd0,
        CMD_MOVE   = 3'd1,
        CMD_REMOVE = 3'd2,
        CMD_GET    = 3'd3,
        CMD_ROUTE  = 3'd4
    } cmd_t;

    typedef logic [IDS_PER_SET-1:0] used_mask_t;

endpackage

// ===== rtl/wst_ram.sv =====
module wst_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 72
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/waypoint_slot_table.sv =====
// Channel   Handshake            Fields
// command   start / busy         cmd, set_num, entry_id, pos_x, pos_y, route_value
// result    done (one cycle)     new_id, found, out_x, out_y, changed, route_out
//
// One transaction per cycle; busy stays low. The result appears in the cycle after
// acceptance, set by the registered read port of the position RAM.
// Used masks and route flags sit in flops and update at the accept edge, so a
// following transaction sees them; RAM writes land at the accept edge too.
// Reset clears masks, route flags and done; the position RAM is not cleared.
// The receiver cannot stall; each result is valid for exactly one cycle.
module waypoint_slot_table (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [wst_pkg::CMD_W-1:0]           cmd,
    input  logic [wst_pkg::SETNUM_W-1:0]        set_num,
    input  logic [wst_pkg::ID_W-1:0]            entry_id,
    input  logic signed [wst_pkg::POS_W-1:0]    pos_x,
    input  logic signed [wst_pkg::POS_W-1:0]    pos_y,
    input  logic                                route_value,
    output logic                                done,
    output logic [wst_pkg::ID_W-1:0]            new_id,
    output logic                                found,
    output logic signed [wst_pkg::POS_W-1:0]    out_x,
    output logic signed [wst_pkg::POS_W-1:0]    out_y,
    output logic                                changed,
    output logic                                route_out
);

    localparam int CW = wst_pkg::COORD_WIDTH;

    wst_pkg::used_mask_t                  used_reg [wst_pkg::NUM_SETS];
    wst_pkg::used_mask_t                  used_next;
    logic                                 route_reg [wst_pkg::NUM_SETS];
    logic                                 route_next;

    logic                                 done_reg;
    logic [wst_pkg::ID_W-1:0]             new_id_reg;
    logic [wst_pkg::ID_W-1:0]             new_id_next;
    logic                                 found_reg;
    logic                                 found_next;
    logic                                 hit_reg;
    logic                                 hit_next;
    logic                                 changed_reg;
    logic                                 changed_next;
    logic                                 route_out_reg;
    logic                                 route_out_next;

    logic                                 accept;
    logic                                 set_ok;
    logic                                 id_ok;
    logic [wst_pkg::SETNUM_W-1:0]         set_m1;
    logic [wst_pkg::ID_W-1:0]             id_m1;
    logic [wst_pkg::SET_IDX_W-1:0]        si;
    logic [wst_pkg::SLOT_IDX_W-1:0]       idx;
    wst_pkg::used_mask_t                  cur_mask;
    logic                                 cur_used;
    logic                                 free_any;
    logic [wst_pkg::SLOT_IDX_W-1:0]       free_idx;
    logic [wst_pkg::SLOT_ADDR_W-1:0]      set_base;
    logic [wst_pkg::SLOT_ADDR_W-1:0]      id_addr;
    logic [wst_pkg::SLOT_ADDR_W-1:0]      free_addr;

    logic                                 wr_en;
    logic [wst_pkg::SLOT_ADDR_W-1:0]      wr_addr;
    logic [wst_pkg::SLOT_DATA_W-1:0]      wr_data;
    logic                                 rd_en;
    logic [wst_pkg::SLOT_DATA_W-1:0]      rd_data;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign set_ok = (set_num >= wst_pkg::SETNUM_W'(1)) &&
                    (set_num <= wst_pkg::SETNUM_W'(wst_pkg::NUM_SETS));
    assign id_ok  = (entry_id >= wst_pkg::ID_W'(1)) &&
                    (entry_id <= wst_pkg::ID_W'(wst_pkg::IDS_PER_SET));
    assign set_m1 = set_num - wst_pkg::SETNUM_W'(1);
    assign id_m1  = entry_id - wst_pkg::ID_W'(1);
    assign si     = set_ok ? set_m1[wst_pkg::SET_IDX_W-1:0] : '0;
    assign idx    = id_m1[wst_pkg::SLOT_IDX_W-1:0];

    assign cur_mask = used_reg[si];
    assign cur_used = set_ok && id_ok && cur_mask[idx];

    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int k = wst_pkg::IDS_PER_SET - 1; k >= 0; k--)
        begin
            if (!cur_mask[k])
            begin
                free_any = 1'b1;
                free_idx = wst_pkg::SLOT_IDX_W'(k);
            end
        end
    end

    assign set_base  = wst_pkg::SLOT_ADDR_W'(si) *
                       wst_pkg::SLOT_ADDR_W'(wst_pkg::IDS_PER_SET);
    assign id_addr   = set_base + wst_pkg::SLOT_ADDR_W'(idx);
    assign free_addr = set_base + wst_pkg::SLOT_ADDR_W'(free_idx);
    assign wr_data   = {pos_y[CW-1:0], pos_x[CW-1:0]};

    always_comb
    begin
        used_next      = cur_mask;
        route_next     = route_reg[si];
        new_id_next    = '0;
        found_next     = 1'b0;
        hit_next       = 1'b0;
        changed_next   = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = id_addr;
        rd_en          = 1'b0;
        case (wst_pkg::cmd_t'(cmd))
            wst_pkg::CMD_ADD:
            begin
                if (set_ok && free_any)
                begin
                    used_next[free_idx] = 1'b1;
                    wr_en        = accept;
                    wr_addr      = free_addr;
                    new_id_next  = wst_pkg::ID_W'(free_idx) + wst_pkg::ID_W'(1);
                    changed_next = 1'b1;
                end
            end
            wst_pkg::CMD_MOVE:
            begin
                if (cur_used)
                begin
                    wr_en        = accept;
                    found_next   = 1'b1;
                    changed_next = 1'b1;
                end
            end
            wst_pkg::CMD_REMOVE:
            begin
                if (set_ok && id_ok)
                begin
                    used_next[idx] = 1'b0;
                end
                changed_next = 1'b1;
            end
            wst_pkg::CMD_GET:
            begin
                if (cur_used)
                begin
                    rd_en      = accept;
                    found_next = 1'b1;
                    hit_next   = 1'b1;
                end
            end
            wst_pkg::CMD_ROUTE:
            begin
                if (set_ok)
                begin
                    route_next   = route_value;
                    changed_next = 1'b1;
                end
            end
            default:
            begin
                used_next = cur_mask;
            end
        endcase
        route_out_next = set_ok && route_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
            for (int s = 0; s < wst_pkg::NUM_SETS; s++)
            begin
                used_reg[s]  <= '0;
                route_reg[s] <= 1'b0;
            end
        end
        else
        begin
            done_reg <= accept;
            if (accept && set_ok)
            begin
                used_reg[si]  <= used_next;
                route_reg[si] <= route_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            new_id_reg    <= new_id_next;
            found_reg     <= found_next;
            hit_reg       <= hit_next;
            changed_reg   <= changed_next;
            route_out_reg <= route_out_next;
        end
    end

    wst_ram #(
        .WIDTH (wst_pkg::SLOT_DATA_W),
        .DEPTH (wst_pkg::SLOT_DEPTH)
    ) u_pos_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (id_addr),
        .rd_data (rd_data)
    );

    assign done      = done_reg;
    assign new_id    = new_id_reg;
    assign found     = found_reg;
    assign changed   = changed_reg;
    assign route_out = route_out_reg;
    assign out_x     = hit_reg ? wst_pkg::POS_W'($signed(rd_data[CW-1:0])) : '0;
    assign out_y     = hit_reg ? wst_pkg::POS_W'($signed(rd_data[2*CW-1:CW])) : '0;

`ifndef SYNTHESIS
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy))
        else $error("result strobe without an accepted transaction");

    a_add_id_marks_change: assert property (@(posedge clk) disable iff (!rst_n)
        (done && new_id != '0) |-> (changed && !found))
        else $error("add result inconsistent");

    a_miss_gives_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (out_x == '0 && out_y == '0))
        else $error("position returned without a hit");

    a_single_ram_access: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && rd_en))
        else $error("read and write issued by one transaction");
`endif

endmodule
